@@ rtl/core/accelerated_encoder_setpoint_core_macros.svh @@
// assertion helpers for the encoder setpoint core checker
// each expects clk and rst in the enclosing scope
`ifndef ACCELERATED_ENCODER_SETPOINT_CORE_MACROS_SVH
`define ACCELERATED_ENCODER_SETPOINT_CORE_MACROS_SVH

// same-cycle implication
`define AES_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define AES_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/core/aes_pkg.sv @@
package aes_pkg;

  localparam int CHANNELS   = 2;
  localparam int CH_W       = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int SP_COUNT   = CHANNELS * 2;
  localparam int SP_W       = 16;
  localparam int STEP_W     = 10;
  localparam int IVL_W      = 32;
  localparam int REQ_W      = 2;
  localparam int CFG_IDX_W  = 1;
  localparam int NUM_STEPS  = 32;

  localparam logic [SP_W-1:0] VOLTAGE_LIMIT_RESET = 16'd28500;
  localparam logic [SP_W-1:0] CURRENT_LIMIT_RESET = 16'd2048;

  localparam logic [REQ_W-1:0] REQ_LEFT    = 2'd0;
  localparam logic [REQ_W-1:0] REQ_RIGHT   = 2'd1;
  localparam logic [REQ_W-1:0] REQ_ADVANCE = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_VOLTAGE_LIMIT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_CURRENT_LIMIT = 1'b1;

  localparam logic QTY_VOLTAGE = 1'b0;
  localparam logic QTY_CURRENT = 1'b1;

  typedef enum logic [1:0] {
    OP_DEC,
    OP_INC,
    OP_ADV,
    OP_NOP
  } op_t;

  typedef struct packed {
    op_t               op;
    logic [STEP_W-1:0] step;
  } cmd_t;

  typedef struct packed {
    logic [CH_W-1:0]   sel_channel;
    logic              sel_quantity;
    logic [SP_W-1:0]   setpoint_value;
    logic [STEP_W-1:0] step_applied;
  } result_t;

  typedef struct packed {
    logic [SP_W-1:0] voltage;
    logic [SP_W-1:0] current;
  } limits_t;

  // descending interval thresholds, slowest first
  localparam logic [15:0] THR_TAB [NUM_STEPS] = '{
    16'd65051, 16'd54845, 16'd47930, 16'd42693, 16'd38477, 16'd34948, 16'd31913,
    16'd29251, 16'd26880, 16'd24742, 16'd22796, 16'd21010, 16'd19360, 16'd17827,
    16'd16395, 16'd15051, 16'd13786, 16'd12590, 16'd11457, 16'd10380, 16'd9354,
    16'd8374,  16'd7437,  16'd6538,  16'd5675,  16'd4845,  16'd4046,  16'd3275,
    16'd2530,  16'd1810,  16'd1113,  16'd500
  };

  localparam logic [STEP_W-1:0] STEP_TAB [NUM_STEPS] = '{
    10'd1,   10'd1,   10'd1,   10'd20,  10'd55,  10'd90,  10'd125, 10'd160,
    10'd195, 10'd230, 10'd265, 10'd300, 10'd335, 10'd370, 10'd405, 10'd440,
    10'd475, 10'd510, 10'd545, 10'd580, 10'd615, 10'd650, 10'd685, 10'd720,
    10'd755, 10'd790, 10'd825, 10'd860, 10'd895, 10'd930, 10'd965, 10'd1000
  };

  // first threshold met wins; scan from the end so the earliest hit is kept
  function automatic logic [STEP_W-1:0] step_lookup(input logic [IVL_W-1:0] ivl);
    logic [STEP_W-1:0] step;
    step = '0;
    for (int k = NUM_STEPS - 1; k >= 0; k--) begin
      if (ivl >= {16'd0, THR_TAB[k]}) begin
        step = STEP_TAB[k];
      end
    end
    return step;
  endfunction

endpackage

@@ rtl/core/accelerated_encoder_setpoint_core.sv @@
// encoder setpoint core: keeps a voltage and a current setpoint for each of two
// channels plus a selection pointer (reset: channel 0 voltage, all setpoints 0).
// each input word is a left turn, a right turn or an advance; turns pick a step of
// 1..1000 from the detent interval (intervals below 500 give no change), left turns
// saturate at 0 and right turns clamp at the configured limit for the selected
// quantity. every input word yields exactly one result word with the selection and
// setpoint after the event. sustained rate is one word per clock while results are
// popped; an accepted word passes the front classify register, then the command
// queue, and the back end updates the setpoint and writes the result queue in the
// same cycle. full only rises when both queues back up behind a stalled pop.
// limits are written through the cfg port (index 0 voltage, 1 current), ready
// always high, and should only change while the block is idle.
module accelerated_encoder_setpoint_core import aes_pkg::*; #(
  parameter int CMDQ_DEPTH = 2,
  parameter int RESQ_DEPTH = 2
) (
  input  logic                 clk,
  input  logic                 rst,
  // request side
  input  logic                 push,
  output logic                 full,
  input  logic [REQ_W-1:0]     req_type,
  input  logic [IVL_W-1:0]     interval,
  // result side
  output logic                 empty,
  input  logic                 pop,
  output logic [CH_W-1:0]      sel_channel,
  output logic                 sel_quantity,
  output logic [SP_W-1:0]      setpoint_value,
  output logic [STEP_W-1:0]    step_applied,
  // register writes
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [SP_W-1:0]      cfg_data
);

  // limit registers
  limits_t limits;

  // front to command queue
  logic    front_valid;
  cmd_t    front_cmd;
  logic    cmdq_full;

  // command queue to back end
  logic [$bits(cmd_t)-1:0] cmdq_rdata;
  cmd_t    back_cmd;
  logic    cmdq_empty;
  logic    cmdq_pop;

  // back end to result queue
  logic    res_push;
  result_t res_word;
  logic    resq_full;
  logic [$bits(result_t)-1:0] resq_rdata;
  result_t out_word;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      limits.voltage <= VOLTAGE_LIMIT_RESET;
      limits.current <= CURRENT_LIMIT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_VOLTAGE_LIMIT: limits.voltage <= cfg_data;
        REG_CURRENT_LIMIT: limits.current <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // decode request and look up the step size
  aes_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .req_type  (req_type),
    .interval  (interval),
    .cmd_valid (front_valid),
    .cmd       (front_cmd),
    .cmd_full  (cmdq_full)
  );

  // decouples decode from the setpoint update
  aes_fifo #(
    .WIDTH ($bits(cmd_t)),
    .DEPTH (CMDQ_DEPTH)
  ) u_cmdq (
    .clk   (clk),
    .rst   (rst),
    .push  (front_valid),
    .wdata (front_cmd),
    .full  (cmdq_full),
    .pop   (cmdq_pop),
    .rdata (cmdq_rdata),
    .empty (cmdq_empty)
  );

  assign back_cmd = cmd_t'(cmdq_rdata);

  // read-modify-write of the selected setpoint, selection stepping
  aes_back u_back (
    .clk       (clk),
    .rst       (rst),
    .limits    (limits),
    .cmd       (back_cmd),
    .cmd_empty (cmdq_empty),
    .cmd_pop   (cmdq_pop),
    .res_push  (res_push),
    .res       (res_word),
    .res_full  (resq_full)
  );

  // result words wait here until popped
  aes_fifo #(
    .WIDTH ($bits(result_t)),
    .DEPTH (RESQ_DEPTH)
  ) u_resq (
    .clk   (clk),
    .rst   (rst),
    .push  (res_push),
    .wdata (res_word),
    .full  (resq_full),
    .pop   (pop),
    .rdata (resq_rdata),
    .empty (empty)
  );

  assign out_word       = result_t'(resq_rdata);
  assign sel_channel    = out_word.sel_channel;
  assign sel_quantity   = out_word.sel_quantity;
  assign setpoint_value = out_word.setpoint_value;
  assign step_applied   = out_word.step_applied;

endmodule

@@ rtl/core/aes_fifo.sv @@
module aes_fifo import aes_pkg::*; #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

@@ rtl/core/aes_front.sv @@
module aes_front import aes_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  output logic             full,
  input  logic [REQ_W-1:0] req_type,
  input  logic [IVL_W-1:0] interval,
  output logic             cmd_valid,
  output cmd_t             cmd,
  input  logic             cmd_full
);

  logic valid;
  cmd_t cmd_reg;
  cmd_t cmd_next;
  logic take;

  // front register can refill in the same cycle it drains
  assign full      = valid && cmd_full;
  assign take      = push && !full;
  assign cmd_valid = valid;
  assign cmd       = cmd_reg;

  always_comb begin
    cmd_next.step = '0;
    unique case (req_type)
      REQ_LEFT: begin
        cmd_next.op   = OP_DEC;
        cmd_next.step = step_lookup(interval);
      end
      REQ_RIGHT: begin
        cmd_next.op   = OP_INC;
        cmd_next.step = step_lookup(interval);
      end
      REQ_ADVANCE: begin
        cmd_next.op = OP_ADV;
      end
      default: begin
        cmd_next.op = OP_NOP;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (take) begin
      valid <= 1'b1;
    end else if (!cmd_full) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      cmd_reg <= cmd_next;
    end
  end

endmodule

@@ rtl/core/aes_back.sv @@
module aes_back import aes_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  limits_t limits,
  input  cmd_t    cmd,
  input  logic    cmd_empty,
  output logic    cmd_pop,
  output logic    res_push,
  output result_t res,
  input  logic    res_full
);

  logic [SP_W-1:0] sp [SP_COUNT];
  logic [CH_W-1:0] cur_channel;
  logic            cur_quantity;
  logic [CH_W-1:0] cur_channel_next;
  logic            cur_quantity_next;
  logic [CH_W:0]   idx;
  logic [CH_W:0]   idx_next;
  logic [SP_W-1:0] value;
  logic [SP_W-1:0] value_next;
  logic [SP_W-1:0] lim;
  logic [SP_W:0]   sum;
  logic            write_sp;
  logic            fire;

  assign fire     = !cmd_empty && !res_full;
  assign cmd_pop  = fire;
  assign res_push = fire;

  assign idx   = {cur_channel, cur_quantity};
  assign value = sp[idx];
  assign lim   = (cur_quantity == QTY_CURRENT) ? limits.current : limits.voltage;
  assign sum   = {1'b0, value} + (SP_W + 1)'(cmd.step);

  always_comb begin
    cur_channel_next  = cur_channel;
    cur_quantity_next = cur_quantity;
    value_next        = value;
    write_sp          = 1'b0;
    unique case (cmd.op)
      OP_DEC: begin
        if (cmd.step != '0) begin
          write_sp   = 1'b1;
          value_next = (value < SP_W'(cmd.step)) ? '0 : value - SP_W'(cmd.step);
        end
      end
      OP_INC: begin
        if (cmd.step != '0) begin
          write_sp   = 1'b1;
          value_next = (sum > {1'b0, lim}) ? lim : sum[SP_W-1:0];
        end
      end
      OP_ADV: begin
        if (cur_quantity == QTY_VOLTAGE) begin
          cur_quantity_next = QTY_CURRENT;
        end else begin
          cur_quantity_next = QTY_VOLTAGE;
          cur_channel_next  = (cur_channel == CH_W'(CHANNELS - 1)) ? '0
                                                                   : cur_channel + 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  assign idx_next = {cur_channel_next, cur_quantity_next};

  // advance shows the newly selected setpoint, turns show the updated one
  always_comb begin
    res.sel_channel    = cur_channel_next;
    res.sel_quantity   = cur_quantity_next;
    res.setpoint_value = (cmd.op == OP_ADV) ? sp[idx_next] : value_next;
    res.step_applied   = (cmd.op == OP_DEC || cmd.op == OP_INC) ? cmd.step : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_channel  <= '0;
      cur_quantity <= QTY_VOLTAGE;
      for (int k = 0; k < SP_COUNT; k++) begin
        sp[k] <= '0;
      end
    end else if (fire) begin
      cur_channel  <= cur_channel_next;
      cur_quantity <= cur_quantity_next;
      if (write_sp) begin
        sp[idx] <= value_next;
      end
    end
  end

endmodule

@@ rtl/core/aes_checker.sv @@
`include "accelerated_encoder_setpoint_core_macros.svh"

module aes_checker import aes_pkg::*; (
  input logic                 clk,
  input logic                 rst,
  input logic                 empty,
  input logic                 pop,
  input logic [CH_W-1:0]      sel_channel,
  input logic                 sel_quantity,
  input logic [SP_W-1:0]      setpoint_value,
  input logic [STEP_W-1:0]    step_applied,
  input logic                 cfg_valid,
  input logic                 cfg_ready
);

  // register port never stalls
  `AES_ASSERT_NOW(a_cfg_ready, cfg_valid, cfg_ready, "cfg write stalled")

  // step never exceeds the fastest table entry
  `AES_ASSERT_NOW(a_step_max, !empty, step_applied <= 10'd1000, "step above 1000")

  // smallest nonzero step in the table is 1, next is 20
  `AES_ASSERT_NOW(a_step_gap, !empty && step_applied != '0 && step_applied < 10'd20,
                  step_applied == 10'd1, "step not from table")

  // an unpopped result word holds
  `AES_ASSERT_NEXT(a_res_hold, !empty && !pop,
                   !empty && $stable(setpoint_value) && $stable(sel_channel) && $stable(sel_quantity) && $stable(step_applied),
                   "waiting result word changed")

endmodule

bind accelerated_encoder_setpoint_core aes_checker u_aes_checker (.*);
